/* rtl/char_lcd_controller_write_core_macros.svh */
// assertion macros for the character lcd write core checker
`ifndef CHAR_LCD_CONTROLLER_WRITE_CORE_MACROS_SVH
`define CHAR_LCD_CONTROLLER_WRITE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CLCD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clcd assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CLCD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clcd assertion failed");

`endif

/* rtl/clcd_pkg.sv */
// shared types and constants for the character lcd write core
package clcd_pkg;

	localparam int LINE_LENGTH_DEF = 40;
	localparam int CG_DEPTH = 64;

	typedef enum logic [1:0] {
		KIND_INSTR   = 2'd0,
		KIND_DATA    = 2'd1,
		KIND_READ_DD = 2'd2,
		KIND_READ_CG = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic capture;
	} dp_cmd_t;

	typedef struct packed {
		logic shift_on;
		logic increment;
		logic blink_on;
		logic cursor_on;
		logic display_on;
		logic font;
		logic two_line;
		logic eight_bit;
	} flags_t;

	localparam flags_t FLAGS_RESET = flags_t'(8'h40);

	localparam logic [7:0] INS_FUNC_MASK  = 8'he0;
	localparam logic [7:0] INS_FUNC_CODE  = 8'h20;
	localparam logic [7:0] INS_DISP_MASK  = 8'hf8;
	localparam logic [7:0] INS_DISP_CODE  = 8'h08;
	localparam logic [7:0] INS_CLEAR      = 8'h01;
	localparam logic [7:0] INS_HOME_MASK  = 8'hfe;
	localparam logic [7:0] INS_HOME_CODE  = 8'h02;
	localparam logic [7:0] INS_ENTRY_MASK = 8'hfc;
	localparam logic [7:0] INS_ENTRY_CODE = 8'h04;
	localparam logic [7:0] INS_CGA_MASK   = 8'hc0;
	localparam logic [7:0] INS_CGA_CODE   = 8'h40;
	localparam logic [7:0] INS_DDA_MASK   = 8'h80;

	localparam logic [7:0] SPACE_CHAR = 8'h20;

endpackage

/* rtl/clcd_ctrl.sv */
// sequencer for one transaction: accept, execute, read back, report
module clcd_ctrl import clcd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output logic    done,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		busy        = 1'b1;
		done        = 1'b0;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_READ;
			end
			ST_READ: begin
				cmd.capture = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/clcd_datapath.sv */
// address, flag and ram datapath of the character lcd write core
module clcd_datapath import clcd_pkg::*; #(
	parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	input  kind_t      kind,
	input  logic [7:0] data,
	input  logic [6:0] read_index,
	output logic [7:0] read_value,
	output logic [6:0] dd_address,
	output logic [5:0] cg_address,
	output logic       ram_mode,
	output flags_t     flags
);

	localparam int DD_DEPTH = 2 * LINE_LENGTH;
	localparam int DD_AW = $clog2(DD_DEPTH);
	localparam logic [7:0] DD_DEPTH_B = 8'(DD_DEPTH);
	localparam logic [7:0] LINE_B = 8'(LINE_LENGTH);

	kind_t       kind_q;
	logic [7:0]  data_q;
	logic [6:0]  idx_q;

	logic [7:0]  dd_mem_q [DD_DEPTH];
	logic [4:0]  cg_mem_q [CG_DEPTH];
	logic [DD_DEPTH-1:0] dd_vld_q;
	logic [CG_DEPTH-1:0] cg_vld_q;

	logic [6:0]  dd_addr_q;
	logic [5:0]  cg_addr_q;
	logic        ram_mode_q;
	flags_t      flags_q;

	logic [7:0]  dd_rd_q;
	logic [4:0]  cg_rd_q;
	logic        dd_in_q;
	logic        dd_hit_q;
	logic        cg_in_q;
	logic        cg_hit_q;
	logic [7:0]  read_value_q;

	logic [7:0]  dd_wr_idx;
	logic        dd_wr_ok;
	logic        dd_rd_in;
	logic        cg_rd_in;
	logic        data_exec;

	assign data_exec = cmd.exec && (kind_q == KIND_DATA);
	assign dd_rd_in  = {1'b0, idx_q} < DD_DEPTH_B;
	assign cg_rd_in  = !idx_q[6];

	// line mapping for display writes
	always_comb begin
		if (flags_q.two_line) begin
			dd_wr_idx = (dd_addr_q[6] ? LINE_B : 8'd0) + {2'b00, dd_addr_q[5:0]};
			dd_wr_ok  = {2'b00, dd_addr_q[5:0]} < LINE_B;
		end else begin
			dd_wr_idx = {1'b0, dd_addr_q};
			dd_wr_ok  = {1'b0, dd_addr_q} < DD_DEPTH_B;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			data_q <= data;
			idx_q  <= read_index;
		end
	end

	// ram arrays
	always_ff @(posedge clk) begin
		if (data_exec && ram_mode_q && dd_wr_ok) begin
			dd_mem_q[dd_wr_idx[DD_AW-1:0]] <= data_q;
		end
		if (data_exec && !ram_mode_q) begin
			cg_mem_q[cg_addr_q] <= data_q[4:0];
		end
		if (cmd.exec) begin
			dd_rd_q  <= dd_mem_q[idx_q[DD_AW-1:0]];
			cg_rd_q  <= cg_mem_q[idx_q[5:0]];
			dd_in_q  <= dd_rd_in;
			dd_hit_q <= dd_rd_in && dd_vld_q[idx_q[DD_AW-1:0]];
			cg_in_q  <= cg_rd_in;
			cg_hit_q <= cg_rd_in && cg_vld_q[idx_q[5:0]];
		end
		if (cmd.capture) begin
			case (kind_q)
				KIND_READ_DD: begin
					read_value_q <= dd_hit_q ? dd_rd_q : (dd_in_q ? SPACE_CHAR : 8'd0);
				end
				KIND_READ_CG: begin
					read_value_q <= (cg_in_q && cg_hit_q) ? {3'b000, cg_rd_q} : 8'd0;
				end
				default: begin
					read_value_q <= 8'd0;
				end
			endcase
		end
	end

	// instruction decode and address stepping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dd_vld_q   <= '0;
			cg_vld_q   <= '0;
			dd_addr_q  <= '0;
			cg_addr_q  <= '0;
			ram_mode_q <= 1'b0;
			flags_q    <= FLAGS_RESET;
		end else if (cmd.exec) begin
			case (kind_q)
				KIND_INSTR: begin
					if ((data_q & INS_FUNC_MASK) == INS_FUNC_CODE) begin
						flags_q.eight_bit <= data_q[4];
						flags_q.two_line  <= data_q[3];
						flags_q.font      <= data_q[2];
					end else if ((data_q & INS_DISP_MASK) == INS_DISP_CODE) begin
						flags_q.display_on <= data_q[2];
						flags_q.cursor_on  <= data_q[1];
						flags_q.blink_on   <= data_q[0];
					end else if (data_q == INS_CLEAR) begin
						dd_addr_q         <= '0;
						flags_q.increment <= 1'b1;
						dd_vld_q          <= '0;
					end else if ((data_q & INS_HOME_MASK) == INS_HOME_CODE) begin
						dd_addr_q <= '0;
					end else if ((data_q & INS_ENTRY_MASK) == INS_ENTRY_CODE) begin
						flags_q.increment <= data_q[1];
						flags_q.shift_on  <= data_q[0];
					end else if ((data_q & INS_CGA_MASK) == INS_CGA_CODE) begin
						cg_addr_q  <= data_q[5:0];
						ram_mode_q <= 1'b0;
					end else if ((data_q & INS_DDA_MASK) == INS_DDA_MASK) begin
						dd_addr_q  <= data_q[6:0];
						ram_mode_q <= 1'b1;
					end
				end
				KIND_DATA: begin
					if (!ram_mode_q) begin
						cg_vld_q[cg_addr_q] <= 1'b1;
						cg_addr_q <= flags_q.increment ? cg_addr_q + 6'd1 : cg_addr_q - 6'd1;
					end else begin
						if (dd_wr_ok) begin
							dd_vld_q[dd_wr_idx[DD_AW-1:0]] <= 1'b1;
						end
						dd_addr_q <= flags_q.increment ? dd_addr_q + 7'd1 : dd_addr_q - 7'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign read_value = read_value_q;
	assign dd_address = dd_addr_q;
	assign cg_address = cg_addr_q;
	assign ram_mode   = ram_mode_q;
	assign flags      = flags_q;

endmodule

/* rtl/char_lcd_controller_write_core.sv */
// top level of the character lcd write core
// done pulses for one cycle once the transaction has passed through the exec and read states
// a new transaction is taken only once the four-state sequencer is back in idle
// the display and glyph rams read through one registered port each
// reset zeroes addresses, mode and ram valid bits, flags come up with only increment set
// done cannot be held off; results are valid from done onwards and hold until the next read capture
module char_lcd_controller_write_core import clcd_pkg::*; #(
	parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] kind,
	input  logic [7:0] data,
	input  logic [6:0] read_index,
	output logic       done,
	output logic [7:0] read_value,
	output logic [6:0] dd_address,
	output logic [5:0] cg_address,
	output logic       ram_mode,
	output logic       eight_bit,
	output logic       two_line,
	output logic       font_flag,
	output logic       display_on,
	output logic       cursor_on,
	output logic       blink_on,
	output logic       increment,
	output logic       shift_flag
);

	dp_cmd_t cmd;
	flags_t  flags;

	clcd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	clcd_datapath #(
		.LINE_LENGTH (LINE_LENGTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (kind_t'(kind)),
		.data       (data),
		.read_index (read_index),
		.read_value (read_value),
		.dd_address (dd_address),
		.cg_address (cg_address),
		.ram_mode   (ram_mode),
		.flags      (flags)
	);

	assign eight_bit  = flags.eight_bit;
	assign two_line   = flags.two_line;
	assign font_flag  = flags.font;
	assign display_on = flags.display_on;
	assign cursor_on  = flags.cursor_on;
	assign blink_on   = flags.blink_on;
	assign increment  = flags.increment;
	assign shift_flag = flags.shift_on;

endmodule

/* rtl/clcd_checker.sv */
// port-level checker for the character lcd write core, with its bind
`include "char_lcd_controller_write_core_macros.svh"

module clcd_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// accepted transaction reports with done after passing through the exec and read states
	`CLCD_ASSERT_IMP(a_latency, start && !busy, ##3 done)
	`CLCD_ASSERT_NXT(a_busy_after_accept, start && !busy, busy)
	`CLCD_ASSERT_IMP(a_done_while_busy, done, busy)
	`CLCD_ASSERT_NXT(a_idle_after_done, done, !busy && !done)

endmodule

bind char_lcd_controller_write_core clcd_checker u_clcd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
